// ===== hdl/bounded_fifo_with_stats_macros.svh =====
// Assertion helpers for the queue. Each use expects clk and rst_n in scope.
`ifndef BOUNDED_FIFO_WITH_STATS_MACROS_SVH
`define BOUNDED_FIFO_WITH_STATS_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BFS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bfs assertion failed");

// Antecedent in one cycle forces the consequent in the same cycle
`define BFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfs assertion failed");

// Antecedent in one cycle forces the consequent in the next cycle
`define BFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfs assertion failed");

`endif

// ===== hdl/bfs_pkg.sv =====
package bfs_pkg;

    // Default number of ring slots
    localparam int DEPTH_DEF = 256;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int CNT_W  = 32;
    localparam int OCC_W  = 9;
    localparam int CAP_W  = 9;

    // Capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Request codes
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_GET = 1'b1;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Slot memory access controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

// ===== hdl/bfs_ram.sv =====
module bfs_ram #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  bfs_pkg::ram_ctl_t          ctl,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bfs_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bfs_pkg::DATA_W-1:0] rd_data
);
    import bfs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Slot write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bfs_ctrl.sv =====
module bfs_ctrl #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       action,
    input  logic                       cfg_we,
    input  logic [bfs_pkg::CAP_W-1:0]  cfg_data,
    output bfs_pkg::ram_ctl_t          ram_ctl,
    output logic [ADDR_W-1:0]          head_addr,
    output logic [ADDR_W-1:0]          tail_addr,
    output logic                       done,
    output logic                       status,
    output logic                       pop_ok,
    output logic [bfs_pkg::OCC_W-1:0]  occupancy,
    output logic [bfs_pkg::CNT_W-1:0]  add_tries,
    output logic [bfs_pkg::CNT_W-1:0]  get_tries,
    output logic [bfs_pkg::CNT_W-1:0]  adds_done,
    output logic [bfs_pkg::CNT_W-1:0]  gets_done
);
    import bfs_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

    logic [CAP_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  add_try_reg, add_try_next;
    logic [CNT_W-1:0]  get_try_reg, get_try_next;
    logic [CNT_W-1:0]  add_done_reg, add_done_next;
    logic [CNT_W-1:0]  get_done_reg, get_done_next;
    logic              done_reg, status_reg, status_next, pop_ok_reg;
    logic              is_full, is_empty, add_ok, get_ok;

    // Full against the smaller of the limit and the ring size
    assign is_full  = (32'(fill_reg) >= 32'(cap_reg)) || (32'(fill_reg) >= 32'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign add_ok   = accept && (action == ACT_ADD) && !is_full;
    assign get_ok   = accept && (action == ACT_GET) && !is_empty;

    // Memory requests: write at tail on add, read at head on get
    assign ram_ctl.wr_en = add_ok;
    assign ram_ctl.rd_en = get_ok;
    assign head_addr     = head_reg;
    assign tail_addr     = tail_reg;

    // Pointer, fill and counter updates
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        add_try_next  = add_try_reg;
        get_try_next  = get_try_reg;
        add_done_next = add_done_reg;
        get_done_next = get_done_reg;
        status_next   = status_reg;
        if (accept)
        begin
            status_next = ST_FAIL;
            if (action == ACT_ADD)
            begin
                add_try_next = add_try_reg + 1'b1;
            end
            else
            begin
                get_try_next = get_try_reg + 1'b1;
            end
            if (add_ok)
            begin
                status_next   = ST_OK;
                tail_next     = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                fill_next     = fill_reg + 1'b1;
                add_done_next = add_done_reg + 1'b1;
            end
            if (get_ok)
            begin
                status_next   = ST_OK;
                head_next     = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                fill_next     = fill_reg - 1'b1;
                get_done_next = get_done_reg + 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            add_try_reg  <= '0;
            get_try_reg  <= '0;
            add_done_reg <= '0;
            get_done_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            pop_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            add_try_reg  <= add_try_next;
            get_try_reg  <= get_try_next;
            add_done_reg <= add_done_next;
            get_done_reg <= get_done_next;
            done_reg     <= accept;
            status_reg   <= status_next;
            pop_ok_reg   <= get_ok;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_ok    = pop_ok_reg;
    assign occupancy = fill_reg;
    assign add_tries = add_try_reg;
    assign get_tries = get_try_reg;
    assign adds_done = add_done_reg;
    assign gets_done = get_done_reg;

endmodule

// ===== hdl/bounded_fifo_with_stats.sv =====
// Bounded FIFO of 32-bit values with request statistics. A request is taken
// on any clock edge with start high; busy never rises, so one request per
// cycle is sustained. Each request produces one result in the next cycle, shown
// for a single cycle with done high; the slot memory read is registered like
// done. The receiver cannot stall, so it must capture every result on its done
// cycle. The queue holds at most the smaller of capacity limit and DEPTH values;
// the limit is for the user to write through cfg_we and cfg_data only while no
// request is in flight, unenforced by the block. No clearing pass follows reset.
module bounded_fifo_with_stats #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic signed [bfs_pkg::DATA_W-1:0] push_value,
    input  logic                              cfg_we,
    input  logic [bfs_pkg::CAP_W-1:0]         cfg_data,
    output logic                              done,
    output logic                              status,
    output logic signed [bfs_pkg::DATA_W-1:0] pop_value,
    output logic [bfs_pkg::OCC_W-1:0]         occupancy,
    output logic [bfs_pkg::CNT_W-1:0]         add_tries,
    output logic [bfs_pkg::CNT_W-1:0]         get_tries,
    output logic [bfs_pkg::CNT_W-1:0]         adds_done,
    output logic [bfs_pkg::CNT_W-1:0]         gets_done
);
    import bfs_pkg::*;
    `include "bounded_fifo_with_stats_macros.svh"

    localparam int ADDR_W = $clog2(DEPTH);

    ram_ctl_t          ram_ctl;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] tail_addr;
    logic [DATA_W-1:0] rd_data;
    logic              accept;
    logic              pop_ok;

    // Every request is taken in the cycle it arrives
    assign busy   = 1'b0;
    assign accept = start && !busy;

    bfs_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .ram_ctl   (ram_ctl),
        .head_addr (head_addr),
        .tail_addr (tail_addr),
        .done      (done),
        .status    (status),
        .pop_ok    (pop_ok),
        .occupancy (occupancy),
        .add_tries (add_tries),
        .get_tries (get_tries),
        .adds_done (adds_done),
        .gets_done (gets_done)
    );

    bfs_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (tail_addr),
        .wr_data (push_value),
        .rd_addr (head_addr),
        .rd_data (rd_data)
    );

    // Popped value only on a successful get
    assign pop_value = pop_ok ? signed'(rd_data) : '0;

    // Checks
    `BFS_ASSERT_ALWAYS(a_fill_bound, 32'(occupancy) <= 32'(DEPTH))
    `BFS_ASSERT_NEXT(a_done_follows, accept, done)
    `BFS_ASSERT_NEXT(a_no_spurious, !accept, !done)
    `BFS_ASSERT_SAME(a_fail_zero, done && (status == ST_FAIL), pop_value == '0)

endmodule

// ===== sim/tb_bounded_fifo_with_stats.sv =====
`timescale 1ns / 100ps

module tb_bounded_fifo_with_stats;

    import bfs_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;

    // One result of the queue, as seen on the output ports
    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] pop_value;
        logic [OCC_W-1:0]  occupancy;
        logic [CNT_W-1:0]  add_tries;
        logic [CNT_W-1:0]  get_tries;
        logic [CNT_W-1:0]  adds_done;
        logic [CNT_W-1:0]  gets_done;
    } fifo_result_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // Directed row: a request, or a new capacity limit (held in data)
    typedef struct {
        row_kind_t    kind;
        logic         act;
        logic [31:0]  data;
        bit           typed;
        fifo_result_t want;
    } stim_row_t;

    localparam int N_ROWS = 23;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              action = ACT_ADD;
    logic [DATA_W-1:0] push_value = '0;
    logic              cfg_we = 1'b0;
    logic [CAP_W-1:0]  cfg_data = '0;
    logic              done;
    logic              status;
    logic [DATA_W-1:0] pop_value;
    logic [OCC_W-1:0]  occupancy;
    logic [CNT_W-1:0]  add_tries;
    logic [CNT_W-1:0]  get_tries;
    logic [CNT_W-1:0]  adds_done;
    logic [CNT_W-1:0]  gets_done;

    // Queue state as the testbench expects it
    logic [DATA_W-1:0] model_ring [RING_DEPTH];
    int                model_head = 0;
    int                model_tail = 0;
    int                model_fill = 0;
    logic [CNT_W-1:0]  model_add_tries = '0;
    logic [CNT_W-1:0]  model_get_tries = '0;
    logic [CNT_W-1:0]  model_adds_done = '0;
    logic [CNT_W-1:0]  model_gets_done = '0;
    logic [CAP_W-1:0]  model_limit = CAP_RESET;

    fifo_result_t pending_results [$];
    int           mismatch_count = 0;
    bit           gaps_on = 1'b1;

    stim_row_t directed_rows [N_ROWS] = '{
        // empty queue right after reset, then extremes in and out
        '{ROW_REQ, ACT_GET, 32'h0000_0000, 1'b1, '{ST_FAIL, 32'h0, 9'd0, 32'd0, 32'd1, 32'd0, 32'd0}},
        '{ROW_REQ, ACT_ADD, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 9'd1, 32'd1, 32'd1, 32'd1, 32'd0}},
        '{ROW_REQ, ACT_ADD, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 9'd2, 32'd2, 32'd1, 32'd2, 32'd0}},
        '{ROW_REQ, ACT_ADD, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 9'd3, 32'd3, 32'd1, 32'd3, 32'd0}},
        '{ROW_REQ, ACT_ADD, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 9'd4, 32'd4, 32'd1, 32'd4, 32'd0}},
        '{ROW_REQ, ACT_GET, 32'hA5A5_A5A5, 1'b1,
          '{ST_OK, 32'h7FFF_FFFF, 9'd3, 32'd4, 32'd2, 32'd4, 32'd1}},
        '{ROW_REQ, ACT_GET, 32'h5A5A_5A5A, 1'b1,
          '{ST_OK, 32'h8000_0000, 9'd2, 32'd4, 32'd3, 32'd4, 32'd2}},
        // limit equal to occupancy: add refused
        '{ROW_CFG, ACT_ADD, 32'd2, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'h1234_5678, 1'b1, '{ST_FAIL, 32'h0, 9'd2, 32'd5, 32'd3, 32'd4, 32'd2}},
        // limit below occupancy: adds fail until gets drain the queue below the limit
        '{ROW_CFG, ACT_ADD, 32'd1, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'h5A5A_5A5A, 1'b0, '0},
        '{ROW_REQ, ACT_GET, 32'h0000_0000, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'hFFFF_0000, 1'b0, '0},
        '{ROW_REQ, ACT_GET, 32'h0000_0000, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'h0000_0001, 1'b0, '0},
        // zero limit: every add fails
        '{ROW_CFG, ACT_ADD, 32'd0, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_REQ, ACT_GET, 32'h0000_0000, 1'b0, '0},
        '{ROW_REQ, ACT_GET, 32'hFFFF_FFFF, 1'b0, '0},
        // limit above depth
        '{ROW_CFG, ACT_ADD, 32'd511, 1'b0, '0},
        '{ROW_REQ, ACT_ADD, 32'hDEAD_BEEF, 1'b0, '0},
        '{ROW_REQ, ACT_GET, 32'h0000_0000, 1'b0, '0},
        '{ROW_CFG, ACT_ADD, 32'd256, 1'b0, '0}
    };

    bounded_fifo_with_stats i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .push_value (push_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value),
        .occupancy  (occupancy),
        .add_tries  (add_tries),
        .get_tries  (get_tries),
        .adds_done  (adds_done),
        .gets_done  (gets_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_bounded_fifo_with_stats: errors");
        $finish;
    end

    // Expected result of one request; advances the expected queue state
    task automatic queue_outcome(input logic act, input logic [31:0] data,
                                 output fifo_result_t r);
        int eff_limit;
        eff_limit = (int'(model_limit) > RING_DEPTH) ? RING_DEPTH : int'(model_limit);
        r = '0;
        if (act == ACT_ADD)
        begin
            model_add_tries = model_add_tries + 1;
            if (model_fill >= eff_limit)
                r.status = ST_FAIL;
            else
            begin
                model_ring[model_tail] = data;
                model_tail = (model_tail == RING_DEPTH - 1) ? 0 : model_tail + 1;
                model_fill++;
                model_adds_done = model_adds_done + 1;
            end
        end
        else
        begin
            model_get_tries = model_get_tries + 1;
            if (model_fill == 0)
                r.status = ST_FAIL;
            else
            begin
                r.pop_value = model_ring[model_head];
                model_head = (model_head == RING_DEPTH - 1) ? 0 : model_head + 1;
                model_fill--;
                model_gets_done = model_gets_done + 1;
            end
        end
        r.occupancy = OCC_W'(model_fill);
        r.add_tries = model_add_tries;
        r.get_tries = model_get_tries;
        r.adds_done = model_adds_done;
        r.gets_done = model_gets_done;
    endtask

    // Mostly random words, with the signed extremes, all-ones and zero now and then
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Drive one request, wait for acceptance, record what should come back
    task automatic send_request(input logic act, input logic [31:0] data,
                                input bit typed, input fifo_result_t want);
        fifo_result_t r;
        bit free_now;
        if (gaps_on)
            while ($urandom_range(0, 99) < 21)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start      <= 1'b1;
        action     <= act;
        push_value <= data;
        // busy is stable mid-cycle; sample it there
        do
        begin
            @(negedge clk);
            free_now = !busy;
            @(posedge clk);
        end
        while (!free_now);
        queue_outcome(act, data, r);
        pending_results.push_back(typed ? want : r);
    endtask

    // New capacity limit, written only with nothing in flight
    task automatic set_capacity(input logic [CAP_W-1:0] limit);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_limit = limit;
    endtask

    task automatic random_requests(input int count, input int add_pct);
        for (int k = 0; k < count; k++)
            send_request(($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_GET,
                         random_word(), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp,
                                 input logic [31:0] got);
        if (exp !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp, got);
        end
    endtask

    // Result checker: outputs are stable at the falling edge
    always @(negedge clk)
    begin
        fifo_result_t exp;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end
            else
            begin
                exp = pending_results.pop_front();
                compare_field("status", 32'(exp.status), 32'(status));
                compare_field("pop_value", exp.pop_value, pop_value);
                compare_field("occupancy", 32'(exp.occupancy), 32'(occupancy));
                compare_field("add_tries", exp.add_tries, add_tries);
                compare_field("get_tries", exp.get_tries, get_tries);
                compare_field("adds_done", exp.adds_done, adds_done);
                compare_field("gets_done", exp.gets_done, gets_done);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
                set_capacity(CAP_W'(directed_rows[i].data));
            else
                send_request(directed_rows[i].act, directed_rows[i].data,
                             directed_rows[i].typed, directed_rows[i].want);
        end

        // Fill to the top with the limit above depth, then push into a full ring
        set_capacity(9'd511);
        while (model_fill < RING_DEPTH)
            send_request(($urandom_range(0, 99) < 4) ? ACT_GET : ACT_ADD,
                         random_word(), 1'b0, '0);
        repeat (6) send_request(ACT_ADD, random_word(), 1'b0, '0);

        // Limit just under a full ring
        set_capacity(9'd255);
        random_requests(20, 40);

        // Drain back-to-back with adds locked out, then a few gets on empty
        set_capacity(9'd0);
        gaps_on = 1'b0;
        while (model_fill != 0)
            send_request(($urandom_range(0, 99) < 3) ? ACT_ADD : ACT_GET,
                         random_word(), 1'b0, '0);
        repeat (4) send_request(ACT_GET, random_word(), 1'b0, '0);
        gaps_on = 1'b1;

        // Small limits: frequent full and empty hits while the pointers wrap
        set_capacity(9'd3);
        random_requests(15, 55);
        set_capacity(CAP_W'($urandom_range(1, 12)));
        random_requests(15, 55);
        set_capacity(CAP_RESET);
        random_requests(15, 60);

        // Let the last results come back
        start <= 1'b0;
        for (int w = 0; w < 64 && pending_results.size() != 0; w++)
            @(posedge clk);
        repeat (3) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count += pending_results.size();
            $display("%0t: %0d results never arrived", $realtime, pending_results.size());
        end

        if (mismatch_count == 0)
            $display("tb_bounded_fifo_with_stats: clean");
        else
            $display("tb_bounded_fifo_with_stats: errors");
        $finish;
    end

endmodule
